// File: sv/lrpf_pkg.sv
// ----------------------------------------------------------------------------
// lrpf_pkg
// shared widths, register indexes, reset colours and sequencer states for the
// led ring point fade renderer
// ----------------------------------------------------------------------------
package lrpf_pkg;

    localparam int COLOR_W   = 24;
    localparam int CHAN_W    = 8;
    localparam int NUM_CHANS = 3;
    localparam int LED_W     = 6;
    localparam int POS_W     = 10;
    localparam int SPEED_W   = 6;
    localparam int CFG_IDX_W = 3;

    localparam int NUM_COLOR_REGS = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPEED = 3'd4;

    localparam logic [CHAN_W-1:0] CHAN_MAX = 8'hff;

    localparam logic [COLOR_W-1:0] RESET_COLOR_0 = 24'hff0000;
    localparam logic [COLOR_W-1:0] RESET_COLOR_1 = 24'h00ff00;
    localparam logic [COLOR_W-1:0] RESET_COLOR_2 = 24'hff0000;
    localparam logic [COLOR_W-1:0] RESET_COLOR_3 = 24'h00ff00;
    localparam logic [SPEED_W-1:0] RESET_SPEED   = 6'd1;

    typedef enum logic [7:0] {
        ST_IDLE = 8'b0000_0001,
        ST_MOVE = 8'b0000_0010,
        ST_MOD  = 8'b0000_0100,
        ST_DIST = 8'b0000_1000,
        ST_MAC  = 8'b0001_0000,
        ST_ABS  = 8'b0010_0000,
        ST_DIV  = 8'b0100_0000,
        ST_EMIT = 8'b1000_0000
    } state_t;

endpackage

// File: sv/led_ring_point_fade_renderer.sv
// ----------------------------------------------------------------------------
// led_ring_point_fade_renderer
// renders one colour word per led of a ring on every frame tick
// ----------------------------------------------------------------------------
// s_ channel: one word per frame. s_frame_tick high moves every point forward
//   by point_speed steps and renders the whole ring; a word with s_frame_tick
//   low is taken and dropped. s_ready is high only while the block is idle.
// m_ channel: LED_COUNT words per frame, led_index 0 upwards, last_led set on
//   the final one. One output register decouples the receiver.
// cfg_ channel: cfg_ready is always high; index 0..3 are the point colours,
//   index 4 the speed, anything higher is ignored.
// sequence: the move phase adds the speed to each point in turn and stores
//   it, with an extra step to wrap it when it passes the end of the ring.
//   each led then takes, per point, the distance, then the multiply and
//   accumulate; then the magnitude, the reciprocal multiply that divides by
//   the spread and the hand over of the word.
// reset: colours and speed return to their defaults, points are spread evenly
//   round the ring, the output register is emptied.
// stall: a held output word stops the sequencer before the next word is handed
//   over; the word of the last led waits while a new tick is already taken.
// ----------------------------------------------------------------------------
module led_ring_point_fade_renderer
    import lrpf_pkg::*;
#(
    parameter int LED_COUNT     = 60,
    parameter int POINT_COUNT   = 4,
    parameter int STEPS_PER_LED = 10,
    parameter int SPREAD_LEDS   = 7
) (
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_frame_tick,

    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [LED_W-1:0]     m_led_index,
    output logic [CHAN_W-1:0]    m_red,
    output logic [CHAN_W-1:0]    m_green,
    output logic [CHAN_W-1:0]    m_blue,
    output logic                 m_last_led,

    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [COLOR_W-1:0]   cfg_data
);

    localparam int RING_STEPS  = LED_COUNT * STEPS_PER_LED;
    localparam int SPAN        = SPREAD_LEDS * STEPS_PER_LED;
    localparam int SPAN_W      = $clog2(SPAN + 1);
    localparam int ACC_W       = $clog2(POINT_COUNT * 255 * SPAN + 1);
    localparam int MAG_W       = ACC_W + 1;
    localparam int PT_W        = (POINT_COUNT > 1) ? $clog2(POINT_COUNT) : 1;
    localparam int PROD_W      = CHAN_W + SPAN_W;
    localparam int RECIP_SHIFT = CHAN_W + 2 * $clog2(SPAN);
    localparam int QP_W        = RECIP_SHIFT + CHAN_W;

    localparam logic [POS_W:0]   RING_WIDE  = (POS_W + 1)'(RING_STEPS);
    localparam logic [POS_W-1:0] RING_POS   = POS_W'(RING_STEPS);
    localparam logic [POS_W-1:0] SPAN_POS   = POS_W'(SPAN);
    localparam logic [SPAN_W-1:0] SPAN_VAL  = SPAN_W'(SPAN);
    localparam logic [MAG_W-1:0] FULL_SCALE = MAG_W'(255 * SPAN);
    localparam logic [MAG_W-1:0] SAT_LIMIT  = MAG_W'(256 * SPAN);
    localparam logic [QP_W-1:0]  RECIP      =
        QP_W'(((longint'(1) << RECIP_SHIFT) + longint'(SPAN) - 1) / longint'(SPAN));
    localparam logic [PT_W-1:0]  LAST_PT    = PT_W'(POINT_COUNT - 1);
    localparam logic [LED_W-1:0] LAST_LED   = LED_W'(LED_COUNT - 1);
    localparam logic [POS_W-1:0] STEP_POS   = POS_W'(STEPS_PER_LED);

    state_t state_reg, state_next;

    logic [COLOR_W-1:0] color_reg [NUM_COLOR_REGS];
    logic [SPEED_W-1:0] speed_reg;
    logic [POS_W-1:0]   pos_reg [POINT_COUNT];
    logic [POS_W-1:0]   init_pos [POINT_COUNT];

    logic [PT_W-1:0]    pt_reg;
    logic [LED_W-1:0]   led_reg;
    logic [POS_W-1:0]   led_pos_reg;
    logic [POS_W:0]     sum_reg;
    logic [SPAN_W-1:0]  weight_reg;
    logic [ACC_W-1:0]   acc_reg [NUM_CHANS];
    logic [MAG_W-1:0]   mag_reg [NUM_CHANS];
    logic [CHAN_W-1:0]  quot_reg [NUM_CHANS];
    logic               sat_reg [NUM_CHANS];

    logic               m_valid_reg;
    logic [LED_W-1:0]   m_led_index_reg;
    logic [CHAN_W-1:0]  m_chan_reg [NUM_CHANS];
    logic               m_last_led_reg;

    logic               in_accept;
    logic               out_load;
    logic               pt_last;
    logic [POS_W-1:0]   cur_pos;
    logic [COLOR_W-1:0] cur_color;
    logic [POS_W-1:0]   diff;
    logic [POS_W-1:0]   other;
    logic [POS_W-1:0]   ring_dist;
    logic [SPAN_W-1:0]  weight;
    logic [PROD_W-1:0]  prod [NUM_CHANS];
    logic [MAG_W-1:0]   acc_ext [NUM_CHANS];
    logic [MAG_W-1:0]   mag [NUM_CHANS];
    logic [QP_W-1:0]    quot_prod [NUM_CHANS];

    // evenly spread start positions
    for (genvar g = 0; g < POINT_COUNT; g++) begin : g_init
        localparam int INIT_POS = (g * RING_STEPS) / POINT_COUNT;
        assign init_pos[g] = POS_W'(INIT_POS);
    end

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign in_accept = s_valid && s_ready;
    assign out_load  = (state_reg == ST_EMIT) && (!m_valid_reg || m_ready);
    assign pt_last   = (pt_reg == LAST_PT);

    assign m_valid     = m_valid_reg;
    assign m_led_index = m_led_index_reg;
    assign m_red       = m_chan_reg[0];
    assign m_green     = m_chan_reg[1];
    assign m_blue      = m_chan_reg[2];
    assign m_last_led  = m_last_led_reg;

    // shortest way round the ring and the triangular weight
    always_comb begin
        cur_pos   = pos_reg[pt_reg];
        cur_color = color_reg[2'(pt_reg)];
        diff      = (led_pos_reg >= cur_pos) ? (led_pos_reg - cur_pos)
                                             : (cur_pos - led_pos_reg);
        other     = RING_POS - diff;
        ring_dist = (other < diff) ? other : diff;
        weight    = (ring_dist <= SPAN_POS) ? (SPAN_VAL - ring_dist[SPAN_W-1:0]) : '0;
    end

    // exact division by the spread through its reciprocal
    always_comb begin
        for (int c = 0; c < NUM_CHANS; c++) begin
            prod[c]      = PROD_W'(CHAN_MAX - cur_color[CHAN_W*(NUM_CHANS-1-c) +: CHAN_W])
                           * PROD_W'(weight_reg);
            acc_ext[c]   = MAG_W'(acc_reg[c]);
            mag[c]       = (acc_ext[c] >= FULL_SCALE) ? (acc_ext[c] - FULL_SCALE)
                                                      : (FULL_SCALE - acc_ext[c]);
            quot_prod[c] = QP_W'(mag_reg[c]) * RECIP;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_accept && s_frame_tick) begin
                    state_next = ST_MOVE;
                end
            end
            ST_MOVE: state_next = ST_MOD;
            ST_MOD: begin
                if (sum_reg < RING_WIDE) begin
                    state_next = pt_last ? ST_DIST : ST_MOVE;
                end
            end
            ST_DIST: state_next = ST_MAC;
            ST_MAC:  state_next = pt_last ? ST_ABS : ST_DIST;
            ST_ABS:  state_next = ST_DIV;
            ST_DIV:  state_next = ST_EMIT;
            ST_EMIT: begin
                if (out_load) begin
                    state_next = (led_reg == LAST_LED) ? ST_IDLE : ST_DIST;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // control state and stored point state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            speed_reg   <= RESET_SPEED;
            color_reg[0] <= RESET_COLOR_0;
            color_reg[1] <= RESET_COLOR_1;
            color_reg[2] <= RESET_COLOR_2;
            color_reg[3] <= RESET_COLOR_3;
            for (int i = 0; i < POINT_COUNT; i++) begin
                pos_reg[i] <= init_pos[i];
            end
            pt_reg <= '0;
        end else begin
            state_reg <= state_next;

            if (cfg_valid && cfg_ready) begin
                if (cfg_index < CFG_IDX_SPEED) begin
                    color_reg[cfg_index[1:0]] <= cfg_data;
                end else if (cfg_index == CFG_IDX_SPEED) begin
                    speed_reg <= cfg_data[SPEED_W-1:0];
                end
            end

            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE: pt_reg <= '0;
                ST_MOD: begin
                    if (sum_reg < RING_WIDE) begin
                        pos_reg[pt_reg] <= sum_reg[POS_W-1:0];
                        pt_reg          <= pt_last ? '0 : pt_reg + 1'b1;
                    end
                end
                ST_MAC:  pt_reg <= pt_last ? '0 : pt_reg + 1'b1;
                default: pt_reg <= pt_reg;
            endcase
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_MOVE: sum_reg <= (POS_W + 1)'(cur_pos) + (POS_W + 1)'(speed_reg);
            ST_MOD: begin
                if (sum_reg >= RING_WIDE) begin
                    sum_reg <= sum_reg - RING_WIDE;
                end
                led_reg     <= '0;
                led_pos_reg <= '0;
                for (int c = 0; c < NUM_CHANS; c++) begin
                    acc_reg[c] <= '0;
                end
            end
            ST_DIST: weight_reg <= weight;
            ST_MAC: begin
                for (int c = 0; c < NUM_CHANS; c++) begin
                    acc_reg[c] <= acc_reg[c] + ACC_W'(prod[c]);
                end
            end
            ST_ABS: begin
                for (int c = 0; c < NUM_CHANS; c++) begin
                    mag_reg[c] <= mag[c];
                    sat_reg[c] <= (mag[c] >= SAT_LIMIT);
                end
            end
            ST_DIV: begin
                for (int c = 0; c < NUM_CHANS; c++) begin
                    quot_reg[c] <= quot_prod[c][QP_W-1 -: CHAN_W];
                end
            end
            ST_EMIT: begin
                if (out_load) begin
                    m_led_index_reg <= led_reg;
                    m_last_led_reg  <= (led_reg == LAST_LED);
                    for (int c = 0; c < NUM_CHANS; c++) begin
                        m_chan_reg[c] <= sat_reg[c] ? CHAN_MAX : quot_reg[c];
                        acc_reg[c]    <= '0;
                    end
                    led_reg     <= led_reg + 1'b1;
                    led_pos_reg <= led_pos_reg + STEP_POS;
                end
            end
            default: begin
                sum_reg <= sum_reg;
            end
        endcase
    end

endmodule
